// ----- src/mpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mpf_pkg
// Constants, register indexes and the start code shift search shared by the
// picture framer modules.
// ----------------------------------------------------------------------------
package mpf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_PART_DURATION = 2'd0;
    localparam logic [1:0] CFG_FRAMES_PER_PART = 2'd1;
    localparam logic [1:0] CFG_GOP_ALIGN = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;

    // start code values after the 00 00 01 prefix
    localparam logic [7:0] CODE_PICTURE = 8'h00;
    localparam logic [7:0] CODE_SEQUENCE = 8'hB3;
    localparam logic [7:0] CODE_GOP = 8'hB8;

    // shift search results
    localparam logic [3:0] SHIFT_NONE = 4'd0;
    localparam logic [3:0] SHIFT_ALIGNED = 4'd8;

    // record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // test word is {byte before the zero pair, byte after it}
    function automatic logic [3:0] find_shift(input logic [15:0] test);
        logic [3:0] sh;
        begin
            sh = SHIFT_NONE;
            if ((test & 16'h00FF) == 16'h0001) begin
                sh = SHIFT_ALIGNED;
            end else if ((test & 16'h7F80) == 16'h0080) begin
                sh = 4'd1;
            end else if ((test & 16'h3FC0) == 16'h0040) begin
                sh = 4'd2;
            end else if ((test & 16'h1FE0) == 16'h0020) begin
                sh = 4'd3;
            end else if ((test & 16'h0FF0) == 16'h0010) begin
                sh = 4'd4;
            end else if ((test & 16'h07F8) == 16'h0008) begin
                sh = 4'd5;
            end else if ((test & 16'h03FC) == 16'h0004) begin
                sh = 4'd6;
            end else if ((test & 16'h01FE) == 16'h0002) begin
                sh = 4'd7;
            end
            return sh;
        end
    endfunction

endpackage

// ----- src/mpf_front.sv -----
// ----------------------------------------------------------------------------
// mpf_front
// Byte window, start code detection and picture framing. Builds the records
// caused by each accepted byte and pushes them to the record queue.
// ----------------------------------------------------------------------------
module mpf_front
    import mpf_pkg::*;
#(
    parameter int OFFSET_BITS = 40,
    parameter int ENTRY_W = 2 * (2 * OFFSET_BITS + 8) + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_stream,
    input  logic                   i_q_full,
    output logic                   o_stall,
    output logic                   o_push,
    output logic [ENTRY_W-1:0]     o_entry
);

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start_offset;
        logic [2:0]             start_bit;
        logic [OFFSET_BITS-1:0] end_offset;
        logic [2:0]             end_bit;
        logic                   new_partition;
        logic                   final_picture;
    } t_rec;

    typedef struct packed {
        t_rec rec1;
        t_rec rec0;
        logic two;
    } t_entry;

    logic [7:0]             r_win [5];
    logic [7:0]             n_win [5];
    logic [OFFSET_BITS-1:0] r_count, n_count;
    logic                   r_have_start, n_have_start;
    logic [OFFSET_BITS-1:0] r_pic_start, n_pic_start;
    logic [2:0]             r_pic_start_bit, n_pic_start_bit;
    logic [OFFSET_BITS-1:0] r_pic_end, n_pic_end;
    logic [2:0]             r_pic_end_bit, n_pic_end_bit;
    logic                   r_end_found, n_end_found;
    logic                   r_gop_seen, n_gop_seen;
    logic [31:0]            r_frames, n_frames;

    logic                   r_part_dur;
    logic [31:0]            r_frames_per_part;
    logic                   r_gop_align;

    logic                   accept;
    logic                   examine;
    logic [3:0]             sh;
    logic [15:0]            tail;
    logic [7:0]             code;
    logic                   is_term;
    logic                   found;
    logic                   final_rec;
    logic [OFFSET_BITS-1:0] count_inc;
    t_rec                   rec_found;
    t_rec                   rec_final;
    t_entry                 entry;

    assign accept  = i_valid & ~i_q_full;
    assign o_stall = i_q_full;

    always_comb begin
        n_win           = r_win;
        n_count         = r_count;
        n_have_start    = r_have_start;
        n_pic_start     = r_pic_start;
        n_pic_start_bit = r_pic_start_bit;
        n_pic_end       = r_pic_end;
        n_pic_end_bit   = r_pic_end_bit;
        n_end_found     = r_end_found;
        n_gop_seen      = r_gop_seen;
        n_frames        = r_frames;
        rec_found       = '0;
        rec_final       = '0;
        found           = 1'b0;

        examine = (r_count >= OFFSET_BITS'(4)) && (r_win[1] == 8'h00) && (r_win[2] == 8'h00);
        sh      = examine ? find_shift({r_win[0], r_win[3]}) : SHIFT_NONE;
        tail    = {r_win[3], r_win[4]};
        if (sh == SHIFT_ALIGNED) begin
            code = r_win[4];
        end else begin
            code = tail[(4'd8 - sh) +: 8];
        end
        is_term = (code == CODE_PICTURE) || (code == CODE_SEQUENCE) || (code == CODE_GOP);

        if (sh != SHIFT_NONE) begin
            if (!r_end_found && is_term) begin
                if (sh == SHIFT_ALIGNED) begin
                    n_pic_end     = r_count - OFFSET_BITS'(4);
                    n_pic_end_bit = 3'd0;
                end else begin
                    // boundary is the byte before the zero pair
                    n_pic_end     = r_count - OFFSET_BITS'(5);
                    n_pic_end_bit = sh[2:0];
                end
                n_end_found = 1'b1;
                if (code == CODE_GOP) begin
                    n_gop_seen = 1'b1;
                end
            end
            if (code == CODE_PICTURE) begin
                if (r_have_start) begin
                    found                  = 1'b1;
                    rec_found.start_offset = r_pic_start;
                    rec_found.start_bit    = r_pic_start_bit;
                    rec_found.end_offset   = n_pic_end;
                    rec_found.end_bit      = n_pic_end_bit;
                    if (r_part_dur) begin
                        if ((r_frames >= r_frames_per_part) && (!r_gop_align || n_gop_seen)) begin
                            rec_found.new_partition = 1'b1;
                            n_frames                = '0;
                        end else begin
                            n_frames = r_frames + 32'd1;
                        end
                    end
                end
                n_pic_start     = n_pic_end;
                n_pic_start_bit = n_pic_end_bit;
                n_end_found     = 1'b0;
                n_gop_seen      = 1'b0;
                n_have_start    = 1'b1;
            end
        end

        for (int i = 0; i < 4; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[4]  = i_data_byte;
        count_inc = r_count + OFFSET_BITS'(1);
        n_count   = count_inc;

        rec_final.start_offset  = n_pic_start;
        rec_final.start_bit     = n_pic_start_bit;
        rec_final.end_offset    = count_inc;
        rec_final.final_picture = 1'b1;

        // final record only if a picture start was seen by this byte
        final_rec = i_end_of_stream & n_have_start;

        if (i_end_of_stream) begin
            for (int i = 0; i < 5; i++) begin
                n_win[i] = 8'hFF;
            end
            n_count         = '0;
            n_have_start    = 1'b0;
            n_pic_start     = '0;
            n_pic_start_bit = '0;
            n_pic_end       = '0;
            n_pic_end_bit   = '0;
            n_end_found     = 1'b0;
            n_gop_seen      = 1'b0;
            n_frames        = '0;
        end

        entry.two  = found & final_rec;
        entry.rec0 = found ? rec_found : rec_final;
        entry.rec1 = rec_final;
    end

    assign o_push  = accept & (found | final_rec);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_win[i] <= 8'hFF;
            end
            r_count           <= '0;
            r_have_start      <= 1'b0;
            r_pic_start       <= '0;
            r_pic_start_bit   <= '0;
            r_pic_end         <= '0;
            r_pic_end_bit     <= '0;
            r_end_found       <= 1'b0;
            r_gop_seen        <= 1'b0;
            r_frames          <= '0;
            r_part_dur        <= 1'b0;
            r_frames_per_part <= '0;
            r_gop_align       <= 1'b0;
        end else begin
            if (accept) begin
                r_win           <= n_win;
                r_count         <= n_count;
                r_have_start    <= n_have_start;
                r_pic_start     <= n_pic_start;
                r_pic_start_bit <= n_pic_start_bit;
                r_pic_end       <= n_pic_end;
                r_pic_end_bit   <= n_pic_end_bit;
                r_end_found     <= n_end_found;
                r_gop_seen      <= n_gop_seen;
                r_frames        <= n_frames;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_PART_DURATION:   r_part_dur <= i_cfg_data[0];
                    CFG_FRAMES_PER_PART: r_frames_per_part <= i_cfg_data;
                    CFG_GOP_ALIGN:       r_gop_align <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- src/mpf_back.sv -----
// ----------------------------------------------------------------------------
// mpf_back
// Record queue and output register. Entries hold one or two records; the
// back end hands them out one word at a time and marks the last of each run.
// ----------------------------------------------------------------------------
module mpf_back
    import mpf_pkg::*;
#(
    parameter int OFFSET_BITS = 40,
    parameter int ENTRY_W = 2 * (2 * OFFSET_BITS + 8) + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [ENTRY_W-1:0]     i_entry,
    output logic                   o_full,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [2:0]             o_start_bit,
    output logic [OFFSET_BITS-1:0] o_end_offset,
    output logic [2:0]             o_end_bit,
    output logic                   o_new_partition,
    output logic                   o_final_picture,
    output logic                   o_last_of_run
);

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start_offset;
        logic [2:0]             start_bit;
        logic [OFFSET_BITS-1:0] end_offset;
        logic [2:0]             end_bit;
        logic                   new_partition;
        logic                   final_picture;
    } t_rec;

    typedef struct packed {
        t_rec rec1;
        t_rec rec0;
        logic two;
    } t_entry;

    t_entry                 r_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt, n_cnt;
    logic                   r_sub;
    logic                   r_valid;
    logic                   r_last;
    t_rec                   r_out;

    logic                   load;
    logic                   pop;
    t_entry                 head;

    assign head   = r_q[r_rd];
    assign load   = (!r_valid || !i_stall) && (r_cnt != '0);
    assign pop    = load && (r_sub || !head.two);
    assign o_full = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + QUEUE_CNT_W'(1);
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= t_entry'(i_entry);
        end
        if (load) begin
            r_out  <= r_sub ? head.rec1 : head.rec0;
            r_last <= r_sub || !head.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + QUEUE_PTR_W'(1);
            end
            if (load) begin
                r_valid <= 1'b1;
                if (pop) begin
                    r_rd  <= r_rd + QUEUE_PTR_W'(1);
                    r_sub <= 1'b0;
                end else begin
                    r_sub <= 1'b1;
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_start_offset  = r_out.start_offset;
    assign o_start_bit     = r_out.start_bit;
    assign o_end_offset    = r_out.end_offset;
    assign o_end_bit       = r_out.end_bit;
    assign o_new_partition = r_out.new_partition;
    assign o_final_picture = r_out.final_picture;
    assign o_last_of_run   = r_last;

endmodule

// ----- src/mpeg_picture_framer.sv -----
// ----------------------------------------------------------------------------
// mpeg_picture_framer
// Finds MPEG start codes, aligned or shifted by 1 to 7 bits, in a byte
// stream and emits one record per picture with its byte and bit extent.
// ----------------------------------------------------------------------------
// One byte is taken every cycle. Each byte is examined and framed in the
// cycle it is accepted, and any records it causes go into a four-entry queue
// in front of the output register, so the input only stalls when that queue
// is full. Each record passes from the queue into the output register.
// A byte that both closes a picture and ends the stream gives two records,
// which leave on two consecutive output words. Position p is judged when
// byte p+4 arrives, so the last four bytes of a stream are never examined.
// ----------------------------------------------------------------------------
module mpeg_picture_framer
    import mpf_pkg::*;
#(
    parameter int OFFSET_BITS = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_stream,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [2:0]             o_start_bit,
    output logic [OFFSET_BITS-1:0] o_end_offset,
    output logic [2:0]             o_end_bit,
    output logic                   o_new_partition,
    output logic                   o_final_picture,
    output logic                   o_last_of_run
);

    localparam int ENTRY_W = 2 * (2 * OFFSET_BITS + 8) + 1;

    logic               q_full;
    logic               q_push;
    logic [ENTRY_W-1:0] q_entry;

    mpf_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (q_push),
        .o_entry         (q_entry)
    );

    mpf_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (q_push),
        .i_entry         (q_entry),
        .o_full          (q_full),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_start_offset  (o_start_offset),
        .o_start_bit     (o_start_bit),
        .o_end_offset    (o_end_offset),
        .o_end_bit       (o_end_bit),
        .o_new_partition (o_new_partition),
        .o_final_picture (o_final_picture),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mpeg_picture_framer: byte streams built at bit level
// with aligned and shifted start codes, checked word by word against a
// behavioural picture framer kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
    import mpf_pkg::*;

    localparam int OFF_W = 40;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [OFF_W-1:0] start_offset;
        logic [2:0]       start_bit;
        logic [OFF_W-1:0] end_offset;
        logic [2:0]       end_bit;
        logic             new_partition;
        logic             final_picture;
        logic             last_of_run;
    } picture_rec_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [7:0]             i_data_byte;
    logic                   i_end_of_stream;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [OFF_W-1:0]       o_start_offset;
    logic [2:0]             o_start_bit;
    logic [OFF_W-1:0]       o_end_offset;
    logic [2:0]             o_end_bit;
    logic                   o_new_partition;
    logic                   o_final_picture;
    logic                   o_last_of_run;

    mpeg_picture_framer #(
        .OFFSET_BITS(OFF_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_stream(i_end_of_stream),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_start_offset (o_start_offset),
        .o_start_bit    (o_start_bit),
        .o_end_offset   (o_end_offset),
        .o_end_bit      (o_end_bit),
        .o_new_partition(o_new_partition),
        .o_final_picture(o_final_picture),
        .o_last_of_run  (o_last_of_run)
    );

    // framer model state
    logic [7:0]       recent [0:4];
    logic [OFF_W-1:0] nbytes;
    bit               have_pic;
    logic [OFF_W-1:0] cur_start;
    logic [2:0]       cur_start_bit;
    logic [OFF_W-1:0] cur_end;
    logic [2:0]       cur_end_bit;
    bit               end_seen;
    bit               gop_hit;
    logic [31:0]      pic_in_part;
    bit               part_on;
    logic [31:0]      part_len;
    bit               gop_only;

    picture_rec_t expected_pictures[$];
    bit           code_bits[$];
    logic [7:0]   stream_bytes[$];

    int  bytes_sent = 0;
    int  pictures_checked = 0;
    int  bad_records = 0;
    int  cycle_count = 0;
    bit  tx_random = 0;
    bit  rx_random = 0;
    int  rx_hold_cycles = 0;
    int  hold_left = 0;
    int  burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int prefix_shift(input logic [15:0] probe);
        logic [15:0] moved;
        int s;
        if (probe[7:0] == 8'h01) return 8;
        for (s = 1; s < 8; s++) begin
            moved = probe >> (8 - s);
            if (moved[7:0] == 8'h01) return s;
        end
        return 0;
    endfunction

    function automatic string rec_str(input picture_rec_t r);
        return $sformatf("start %0d.%0d end %0d.%0d part %0b final %0b last %0b",
                         r.start_offset, r.start_bit, r.end_offset, r.end_bit,
                         r.new_partition, r.final_picture, r.last_of_run);
    endfunction

    task automatic clear_framer_model();
        int k;
        for (k = 0; k < 5; k++) recent[k] = 8'hFF;
        nbytes = '0;
        have_pic = 0;
        cur_start = '0;
        cur_start_bit = '0;
        cur_end = '0;
        cur_end_bit = '0;
        end_seen = 0;
        gop_hit = 0;
        pic_in_part = '0;
    endtask

    // position p is judged on arrival of byte p+4, before the window moves
    task automatic frame_byte(input logic [7:0] b, input bit eos);
        picture_rec_t     recs [2];
        logic [OFF_W-1:0] pos;
        logic [15:0]      pair;
        logic [7:0]       code;
        int               sh;
        int               n;
        int               k;
        bit               np;
        n = 0;
        if (nbytes >= 4 && recent[1] == 8'h00 && recent[2] == 8'h00) begin
            pos = nbytes - 4;
            sh = prefix_shift({recent[0], recent[3]});
            if (sh != 0) begin
                pair = {recent[3], recent[4]} >> (8 - (sh % 8));
                code = (sh == 8) ? recent[4] : pair[7:0];
                if (!end_seen && (code == CODE_PICTURE || code == CODE_SEQUENCE ||
                                  code == CODE_GOP)) begin
                    cur_end = (sh == 8) ? pos : pos - 1'b1;
                    cur_end_bit = (sh == 8) ? 3'd0 : 3'(sh);
                    end_seen = 1;
                    if (code == CODE_GOP) gop_hit = 1;
                end
                if (code == CODE_PICTURE) begin
                    if (have_pic) begin
                        np = 0;
                        if (part_on) begin
                            if (pic_in_part >= part_len && (!gop_only || gop_hit)) begin
                                np = 1;
                                pic_in_part = '0;
                            end else begin
                                pic_in_part = pic_in_part + 1'b1;
                            end
                        end
                        recs[n] = '{cur_start, cur_start_bit, cur_end, cur_end_bit,
                                    np, 1'b0, 1'b0};
                        n++;
                    end
                    cur_start = cur_end;
                    cur_start_bit = cur_end_bit;
                    end_seen = 0;
                    gop_hit = 0;
                    have_pic = 1;
                end
            end
        end
        for (k = 0; k < 4; k++) recent[k] = recent[k+1];
        recent[4] = b;
        nbytes = nbytes + 1'b1;
        if (eos) begin
            if (have_pic) begin
                recs[n] = '{cur_start, cur_start_bit, nbytes, 3'd0, 1'b0, 1'b1, 1'b0};
                n++;
            end
            clear_framer_model();
        end
        if (n > 0) recs[n-1].last_of_run = 1'b1;
        for (k = 0; k < n; k++) expected_pictures.push_back(recs[k]);
    endtask

    // ---- stream building, bit by bit so start codes can sit off the byte grid
    task automatic put_bits(input logic [31:0] v, input int nb);
        int k;
        for (k = nb - 1; k >= 0; k--) code_bits.push_back(v[k]);
    endtask

    // shift = number of bits in the byte before the zero run begins
    task automatic put_code(input logic [7:0] code, input int shift);
        int k;
        while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(0, 1)));
        if (shift > 0) begin
            for (k = 0; k < shift - 1; k++) code_bits.push_back(1'($urandom_range(0, 1)));
            code_bits.push_back(1'b1);
        end
        put_bits({24'h000001, code}, 32);
    endtask

    task automatic put_filler(input int nb);
        int k;
        for (k = 0; k < nb; k++) begin
            if ($urandom_range(0, 3) == 0) put_bits(32'h00, 8);
            else put_bits($urandom, 8);
        end
    endtask

    task automatic pack_bits();
        logic [7:0] v;
        int k;
        while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(0, 1)));
        while (code_bits.size() > 0) begin
            v = '0;
            for (k = 0; k < 8; k++) v = {v[6:0], code_bits.pop_front()};
            stream_bytes.push_back(v);
        end
    endtask

    function automatic int rand_shift();
        if ($urandom_range(0, 1) == 1) return 0;
        return $urandom_range(1, 7);
    endfunction

    function automatic int filler_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
        return $urandom_range(0, 4);
    endfunction

    // ---- driving
    task automatic send_byte(input logic [7:0] b, input bit eos);
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_data_byte = b;
        i_end_of_stream = eos;
        do @(posedge i_clk); while (o_stall);
        frame_byte(b, eos);
        bytes_sent++;
        gap = (tx_random && $urandom_range(0, 9) < 3) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_stream();
        int k;
        for (k = 0; k < stream_bytes.size(); k++)
            send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_pictures.size() != 0) @(posedge i_clk);
    endtask

    // a byte may still be in flight after the last record
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            CFG_PART_DURATION:   part_on = val[0];
            CFG_FRAMES_PER_PART: part_len = val;
            CFG_GOP_ALIGN:       gop_only = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // ---- random stream shapes
    task automatic build_video_stream();
        int n_pics;
        int k;
        n_pics = $urandom_range(1, 8);
        put_filler($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
            put_code(CODE_SEQUENCE, rand_shift());
            put_filler($urandom_range(0, 6));
        end
        for (k = 0; k < n_pics; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                put_code(CODE_GOP, rand_shift());
                put_filler($urandom_range(0, 4));
            end
            put_code(CODE_PICTURE, rand_shift());
            put_filler(filler_len());
            // slice and other codes must not frame anything
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1) put_code(8'($urandom_range(1, 8'hAF)), rand_shift());
                else put_code(8'($urandom_range(8'hB0, 8'hFF)), rand_shift());
                put_filler(filler_len());
            end
        end
        put_filler($urandom_range(0, 5));
        pack_bits();
    endtask

    // broken prefixes, zero runs and plain junk, short streams among them
    task automatic build_noise_stream();
        int len;
        int k;
        len = $urandom_range(1, 24);
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 5))
                0, 1: stream_bytes.push_back(8'h00);
                2:    stream_bytes.push_back(8'h01);
                3:    stream_bytes.push_back(8'hFF);
                default: stream_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic random_stream();
        if ($urandom_range(0, 9) < 7) build_video_stream();
        else build_noise_stream();
        send_stream();
    endtask

    // ---- tests
    task automatic test_short_stream();
        put_code(CODE_PICTURE, 0);
        pack_bits();
        send_stream();
    endtask

    // picture at the very start, ended by a GOP, sequence header swallowed,
    // and the last byte both closes a picture and ends the stream
    task automatic test_aligned_codes();
        put_code(CODE_PICTURE, 0);
        put_bits(32'hFF, 8);
        put_code(CODE_GOP, 0);
        put_code(CODE_SEQUENCE, 0);
        put_code(CODE_PICTURE, 0);
        put_bits(32'h00, 8);
        pack_bits();
        send_stream();
    endtask

    task automatic test_shifted_code();
        put_code(CODE_PICTURE, 0);
        put_code(CODE_PICTURE, 7);
        put_bits(32'h00, 8);
        pack_bits();
        send_stream();
    endtask

    // receiver holds off long enough for the record queue to fill
    task automatic test_backpressure();
        int k;
        settle();
        tx_random = 0;
        rx_random = 0;
        for (k = 0; k < 16; k++) put_code(CODE_PICTURE, (k % 3 == 0) ? 0 : k % 8);
        put_filler(2);
        pack_bits();
        rx_hold_cycles = 90;
        send_stream();
        settle();
    endtask

    // sender waits mid-stream until every record is out, then carries on
    task automatic test_mid_stream_pause();
        int k;
        tx_random = 1;
        rx_random = 1;
        build_video_stream();
        for (k = 0; k < stream_bytes.size(); k++) begin
            if (k == stream_bytes.size() / 2) drain_results();
            send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        end
        stream_bytes.delete();
    endtask

    task automatic random_phase(input bit on, input logic [31:0] len, input bit gop,
                                input bit quiet);
        int target;
        settle();
        write_reg(CFG_PART_DURATION, {31'd0, on});
        write_reg(CFG_FRAMES_PER_PART, len);
        write_reg(CFG_GOP_ALIGN, {31'd0, gop});
        tx_random = !quiet;
        rx_random = !quiet;
        target = bytes_sent + 40;
        while (bytes_sent < target) random_stream();
    endtask

    task automatic test_random_streams();
        random_phase(1'b0, 32'd0, 1'b0, 1'b0);
        random_phase(1'b1, 32'd0, 1'b0, 1'b0);
        random_phase(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        random_phase(1'b1, 32'd2, 1'b1, 1'b0);
        random_phase(1'b1, 32'd1, 1'b0, 1'b0);
        random_phase(1'b0, 32'd3, 1'b1, 1'b0);
        while (pictures_checked < 60) random_stream();
    endtask

    // ---- receiver stall
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            hold_left = rx_hold_cycles;
            rx_hold_cycles = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!rx_random) begin
            i_stall <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            burst_left = pick_gap() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---- record checker
    always @(posedge i_clk) begin
        picture_rec_t got;
        picture_rec_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_start_offset, o_start_bit, o_end_offset, o_end_bit,
                    o_new_partition, o_final_picture, o_last_of_run};
            pictures_checked++;
            if (expected_pictures.size() == 0) begin
                bad_records++;
                if (bad_records <= 10)
                    $display("unexpected record at cycle %0d: %s", cycle_count, rec_str(got));
            end else begin
                want = expected_pictures.pop_front();
                if (got != want) begin
                    bad_records++;
                    if (bad_records <= 10)
                        $display("record mismatch at cycle %0d\n  want %s\n  got  %s",
                                 cycle_count, rec_str(want), rec_str(got));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_end_of_stream = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        part_on = 0;
        part_len = '0;
        gop_only = 0;
        clear_framer_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_stream();
        test_aligned_codes();
        test_shifted_code();
        test_backpressure();
        test_mid_stream_pause();
        test_random_streams();

        settle();
        repeat (16) @(posedge i_clk);
        if (bad_records == 0 && expected_pictures.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
